// ===== rtl/slbp_pkg.sv =====
// Package for the status LED blink pattern generator.
// Holds the command and mode codes, the default sizes and the duration tables.
// No dependencies.
package slbp_pkg;

	localparam int PATTERN_LENGTH_DEF = 4;
	localparam int ELAPSED_WIDTH_DEF  = 32;
	localparam int DUR_W              = 13;  // longest duration is 6500 ticks
	localparam int CAPS_BIT           = 1;   // Caps Lock bit of the host LED byte

	typedef logic [DUR_W-1:0] dur_t;

	typedef enum logic [2:0] {
		CMD_TICK       = 3'd0,
		CMD_MOUNT      = 3'd1,
		CMD_UNMOUNT    = 3'd2,
		CMD_SUSPEND    = 3'd3,
		CMD_RESUME     = 3'd4,
		CMD_LED_REPORT = 3'd5
	} cmd_t;

	typedef enum logic [1:0] {
		MODE_NONE        = 2'd0,
		MODE_NOT_MOUNTED = 2'd1,
		MODE_MOUNTED     = 2'd2,
		MODE_SUSPENDED   = 2'd3
	} mode_t;

	// On/off durations in ticks, one four-entry table per blinking mode.
	function automatic dur_t blink_duration(input mode_t mode, input logic [1:0] idx);
		dur_t d;
		d = '0;
		unique case (mode)
			MODE_NONE: begin
				d = '0;
			end
			MODE_NOT_MOUNTED: begin
				d = idx[0] ? DUR_W'(500) : DUR_W'(40);
			end
			MODE_MOUNTED: begin
				d = idx[0] ? DUR_W'(6500) : DUR_W'(10);
			end
			MODE_SUSPENDED: begin
				unique case (idx)
					2'd0: d = DUR_W'(20);
					2'd1: d = DUR_W'(100);
					2'd2: d = DUR_W'(20);
					2'd3: d = DUR_W'(2000);
				endcase
			end
		endcase
		return d;
	endfunction

endpackage

// ===== rtl/status_led_blink_pattern.sv =====
// Status LED blink pattern generator, top level.
// An accepted item passes through the input register, then the result register.
// One item per cycle while the result side does not stall.
// Back-pressure on the result side stalls the input register and the pattern state.
// Reset (arst_n low, asynchronous): mode not mounted, phase 0, elapsed count 0,
// next LED level 0, both pipeline stages empty. Uses slbp_pkg.
module status_led_blink_pattern
	import slbp_pkg::*;
#(
	parameter int PATTERN_LENGTH = PATTERN_LENGTH_DEF,  // 2 .. 16
	parameter int ELAPSED_WIDTH  = ELAPSED_WIDTH_DEF    // 14 .. 32
) (
	input  logic       clk,
	input  logic       arst_n,

	input  logic       in_valid,
	output logic       in_ready,
	input  logic [2:0] command,
	input  logic       report_ok,
	input  logic [7:0] host_led_bits,

	output logic       out_valid,
	input  logic       out_ready,
	output logic       led_write,
	output logic       led_level,
	output logic       caps_write,
	output logic       caps_level
);

	// Phase counter width; a two-entry pattern still needs one bit.
	localparam int PHASE_W = (PATTERN_LENGTH > 2) ? $clog2(PATTERN_LENGTH) : 1;

	// ---------------------------------------------------------------
	// Input register (stage 1)
	// ---------------------------------------------------------------
	logic       valid_s1;
	logic [2:0] command_s1;
	logic       report_ok_s1;
	logic [7:0] host_led_bits_s1;

	// Result register
	logic       out_valid_q;
	logic       led_write_q;
	logic       led_level_q;
	logic       caps_write_q;
	logic       caps_level_q;

	// Pattern state
	mode_t                    mode_q;
	logic [PHASE_W-1:0]       phase_q;
	logic [ELAPSED_WIDTH-1:0] elapsed_q;
	logic                     next_level_q;

	// Stage 1 moves into the result register when that register is empty
	// or is being emptied this cycle; the state updates at the same edge.
	logic advance;
	assign advance  = valid_s1 && (!out_valid_q || out_ready);
	assign in_ready = !valid_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			command_s1       <= command;
			report_ok_s1     <= report_ok;
			host_led_bits_s1 <= host_led_bits;
		end
	end

	// ---------------------------------------------------------------
	// Single-pass update logic
	// ---------------------------------------------------------------
	logic [PHASE_W:0]         phase_ext;
	logic [ELAPSED_WIDTH-1:0] elapsed_inc;
	logic [ELAPSED_WIDTH-1:0] dur_ext;
	dur_t                     dur;

	mode_t                    mode_d;
	logic [PHASE_W-1:0]       phase_d;
	logic [ELAPSED_WIDTH-1:0] elapsed_d;
	logic                     next_level_d;
	logic                     led_write_d;
	logic                     led_level_d;
	logic                     caps_write_d;
	logic                     caps_level_d;

	// Tables are read at phase mod 4.
	assign phase_ext   = {1'b0, phase_q};
	assign dur         = blink_duration(mode_q, phase_ext[1:0]);
	assign dur_ext     = ELAPSED_WIDTH'(dur);
	// Saturating increment of the elapsed count.
	assign elapsed_inc = (&elapsed_q) ? elapsed_q : elapsed_q + 1'b1;

	always_comb begin
		mode_d       = mode_q;
		phase_d      = phase_q;
		elapsed_d    = elapsed_q;
		next_level_d = next_level_q;
		led_write_d  = 1'b0;
		led_level_d  = 1'b0;
		caps_write_d = 1'b0;
		caps_level_d = 1'b0;
		unique case (command_s1)
			CMD_TICK: begin
				elapsed_d = elapsed_inc;
				if (mode_q != MODE_NONE && elapsed_inc >= dur_ext) begin
					elapsed_d    = elapsed_inc - dur_ext;
					phase_d      = (phase_q == PHASE_W'(PATTERN_LENGTH - 1)) ?
						'0 : phase_q + 1'b1;
					led_write_d  = 1'b1;
					led_level_d  = next_level_q;
					next_level_d = !next_level_q;
				end
			end
			CMD_MOUNT, CMD_RESUME: begin
				mode_d = MODE_MOUNTED;
			end
			CMD_UNMOUNT: begin
				mode_d = MODE_NOT_MOUNTED;
			end
			CMD_SUSPEND: begin
				mode_d = MODE_SUSPENDED;
			end
			CMD_LED_REPORT: begin
				// Caps Lock on freezes the pattern with both LEDs lit;
				// off darkens both and returns to the mounted pattern.
				if (report_ok_s1) begin
					led_write_d  = 1'b1;
					caps_write_d = 1'b1;
					if (host_led_bits_s1[CAPS_BIT]) begin
						mode_d       = MODE_NONE;
						led_level_d  = 1'b1;
						caps_level_d = 1'b1;
					end else begin
						mode_d = MODE_MOUNTED;
					end
				end
			end
			default: begin
				// unused codes: no change, no LED driven
			end
		endcase
	end

	// ---------------------------------------------------------------
	// State and result registers
	// ---------------------------------------------------------------
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q       <= MODE_NOT_MOUNTED;
			phase_q      <= '0;
			elapsed_q    <= '0;
			next_level_q <= 1'b0;
		end else if (advance) begin
			mode_q       <= mode_d;
			phase_q      <= phase_d;
			elapsed_q    <= elapsed_d;
			next_level_q <= next_level_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			led_write_q  <= led_write_d;
			led_level_q  <= led_level_d;
			caps_write_q <= caps_write_d;
			caps_level_q <= caps_level_d;
		end
	end

	assign out_valid  = out_valid_q;
	assign led_write  = led_write_q;
	assign led_level  = led_level_q;
	assign caps_write = caps_write_q;
	assign caps_level = caps_level_q;

endmodule

// ===== rtl/slbp_checker.sv =====
// Port-level checker for the status LED blink pattern generator.
// Watches the result channel of status_led_blink_pattern; bound below.
// Uses slbp_pkg.
module slbp_checker
	import slbp_pkg::*;
(
	input logic clk,
	input logic arst_n,
	input logic out_valid,
	input logic out_ready,
	input logic led_write,
	input logic led_level,
	input logic caps_write,
	input logic caps_level
);

	// A stalled result item holds.
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid &&
			$stable({led_write, led_level, caps_write, caps_level}))
		else $error("result item changed while stalled");

	// The caps LED is only driven by a report, which always drives the board
	// LED to the same level.
	a_caps_pair: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && caps_write |-> led_write && (led_level == caps_level))
		else $error("caps LED driven without matching board LED");

	a_led_idle: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !led_write |-> !led_level && !caps_write)
		else $error("board LED level or caps write without board LED write");

	a_caps_idle: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !caps_write |-> !caps_level)
		else $error("caps LED level without caps write");

endmodule

bind status_led_blink_pattern slbp_checker u_slbp_checker (.*);
